FILE: design/rgbpwm_pkg.sv
package rgbpwm_pkg;

  localparam int unsigned DUTY_W = 12;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ACCUM_W = 7;
  localparam int unsigned COLOUR_W = 3;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 12'd4095;
  localparam logic [DUTY_W-1:0] FADE_STEP_RESET = 12'd15;
  localparam logic [ACCUM_W-1:0] ACCUM_SAT = 7'd100;
  localparam logic [ACCUM_W-1:0] PCT_MAX = 7'd99;
  localparam logic [COLOUR_W-1:0] COLOUR_LAST = 3'd6;

  // duty = floor(v * 4095 / 99) = (v * SCALE_MULT) >> SCALE_SHIFT for v <= 99
  localparam int unsigned SCALE_SHIFT = 25;
  localparam int unsigned SCALE_PROD_W = 38;
  localparam logic [SCALE_PROD_W-1:0] SCALE_MULT = 38'd1387934730;

  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_VT = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_D_UP = 8'h44;
  localparam logic [CHAR_W-1:0] CH_D_LO = 8'h64;
  localparam logic [CHAR_W-1:0] CH_R_UP = 8'h52;
  localparam logic [CHAR_W-1:0] CH_R_LO = 8'h72;
  localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CH_B_UP = 8'h42;
  localparam logic [CHAR_W-1:0] CH_B_LO = 8'h62;

  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // bit 0 red, bit 1 green, bit 2 blue
  function automatic logic [2:0] colour_mask(input logic [COLOUR_W-1:0] idx);
    logic [2:0] mask;
    unique case (idx)
      3'd0:    mask = 3'd1;
      3'd1:    mask = 3'd2;
      3'd2:    mask = 3'd4;
      3'd3:    mask = 3'd3;
      3'd4:    mask = 3'd6;
      3'd5:    mask = 3'd5;
      default: mask = 3'd7;
    endcase
    return mask;
  endfunction

endpackage

FILE: design/rgb_pwm_command_and_fade.sv
// Data path: the input register feeds the duty/result register, which drives the outputs.
// Throughput: one item per cycle while the result is not stalled; the input register and
//   the duty/result register form two stages. While the result is stalled the input
//   register takes one more transfer, then the input stalls.
// Reset (rst_ni low, asynchronous): empty pipeline, duties zero, demo off,
//   empty line, intensity zero ramping up, fade_step 15.
module rgb_pwm_command_and_fade
  import rgbpwm_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fade_step_we_i,
  input  logic [DUTY_W-1:0] fade_step_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [CHAR_W-1:0] rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DUTY_W-1:0] duty_red_o,
  output logic [DUTY_W-1:0] duty_green_o,
  output logic [DUTY_W-1:0] duty_blue_o,
  output logic              demo_active_o
);

  localparam int unsigned CNT_W = $clog2(LINE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MIN_CHAN = CNT_W'(3);

  logic                in_valid_q, in_valid_d;
  logic                action_q;
  logic [CHAR_W-1:0]   byte_q;
  logic                out_valid_q, out_valid_d;
  logic [DUTY_W-1:0]   fade_step_q;

  logic [CNT_W-1:0]    line_cnt_q, line_cnt_d;
  logic [CHAR_W-1:0]   first_char_q, first_char_d;
  phase_e              phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [ACCUM_W-1:0]  accum_q, accum_d;
  logic                demo_q, demo_d;
  logic [DUTY_W-1:0]   intensity_q, intensity_d;
  logic                rising_q, rising_d;
  logic [COLOUR_W-1:0] colour_q, colour_d;
  logic [DUTY_W-1:0]   duty_r_q, duty_r_d;
  logic [DUTY_W-1:0]   duty_g_q, duty_g_d;
  logic [DUTY_W-1:0]   duty_b_q, duty_b_d;

  logic                advance;
  logic                in_load;
  logic                is_digit, is_blank, is_eol;
  logic [9:0]          accum_next;
  logic [ACCUM_W-1:0]  pct;
  logic [SCALE_PROD_W-1:0] scale_prod;
  logic [DUTY_W-1:0]   ccr;
  logic [DUTY_W:0]     ramp_sum;
  logic [2:0]          mask;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  assign is_eol   = (byte_q == CH_LF) || (byte_q == CH_CR);
  assign is_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign is_blank = (byte_q == CH_SPACE) || (byte_q == CH_TAB) ||
                    (byte_q == CH_VT) || (byte_q == CH_FF);

  assign accum_next = ({3'b0, accum_q} << 3) + ({3'b0, accum_q} << 1) +
                      10'(byte_q - CH_ZERO);

  assign pct        = neg_q ? '0 : ((accum_q > PCT_MAX) ? PCT_MAX : accum_q);
  assign scale_prod = SCALE_PROD_W'(pct) * SCALE_MULT;
  assign ccr        = scale_prod[SCALE_SHIFT +: DUTY_W];

  assign ramp_sum = {1'b0, intensity_q} + {1'b0, fade_step_q};
  assign mask     = colour_mask(colour_q);

  always_comb begin
    in_valid_d   = in_load || (in_valid_q && !advance);
    out_valid_d  = advance || (out_valid_q && out_stall_i);
    line_cnt_d   = line_cnt_q;
    first_char_d = first_char_q;
    phase_d      = phase_q;
    neg_d        = neg_q;
    accum_d      = accum_q;
    demo_d       = demo_q;
    intensity_d  = intensity_q;
    rising_d     = rising_q;
    colour_d     = colour_q;
    duty_r_d     = duty_r_q;
    duty_g_d     = duty_g_q;
    duty_b_d     = duty_b_q;

    if (advance) begin
      if (action_q) begin
        if (demo_q) begin
          duty_r_d = mask[0] ? intensity_q : '0;
          duty_g_d = mask[1] ? intensity_q : '0;
          duty_b_d = mask[2] ? intensity_q : '0;
          if (rising_q) begin
            if (ramp_sum >= {1'b0, DUTY_MAX}) begin
              intensity_d = DUTY_MAX;
              rising_d    = 1'b0;
            end else begin
              intensity_d = ramp_sum[DUTY_W-1:0];
            end
          end else if (intensity_q >= fade_step_q) begin
            intensity_d = intensity_q - fade_step_q;
          end else begin
            intensity_d = '0;
            rising_d    = 1'b1;
            colour_d    = (colour_q == COLOUR_LAST) ? '0 : colour_q + 1'b1;
          end
        end
      end else if (is_eol) begin
        if (line_cnt_q != '0) begin
          if (first_char_q == CH_D_LO || first_char_q == CH_D_UP) begin
            demo_d = !demo_q;
            if (demo_q) begin
              duty_r_d = '0;
              duty_g_d = '0;
              duty_b_d = '0;
            end
          end else if (!demo_q && line_cnt_q >= CNT_MIN_CHAN) begin
            if (first_char_q == CH_R_LO || first_char_q == CH_R_UP) begin
              duty_r_d = ccr;
            end else if (first_char_q == CH_G_LO || first_char_q == CH_G_UP) begin
              duty_g_d = ccr;
            end else if (first_char_q == CH_B_LO || first_char_q == CH_B_UP) begin
              duty_b_d = ccr;
            end
          end
          line_cnt_d = '0;
          phase_d    = PH_BLANK;
          neg_d      = 1'b0;
          accum_d    = '0;
        end
      end else if (line_cnt_q < CNT_LAST) begin
        line_cnt_d = line_cnt_q + 1'b1;
        if (line_cnt_q == '0) begin
          first_char_d = byte_q;
          phase_d      = PH_BLANK;
          neg_d        = 1'b0;
          accum_d      = '0;
        end else if (phase_q == PH_BLANK && is_blank) begin
          phase_d = PH_BLANK;
        end else if (phase_q == PH_BLANK &&
                     (byte_q == CH_PLUS || byte_q == CH_MINUS)) begin
          neg_d   = (byte_q == CH_MINUS);
          phase_d = PH_SIGN;
        end else if (phase_q != PH_DONE) begin
          if (is_digit) begin
            accum_d = (accum_next > 10'(ACCUM_SAT)) ? ACCUM_SAT : accum_next[ACCUM_W-1:0];
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      fade_step_q  <= FADE_STEP_RESET;
      line_cnt_q   <= '0;
      first_char_q <= '0;
      phase_q      <= PH_BLANK;
      neg_q        <= 1'b0;
      accum_q      <= '0;
      demo_q       <= 1'b0;
      intensity_q  <= '0;
      rising_q     <= 1'b1;
      colour_q     <= '0;
      duty_r_q     <= '0;
      duty_g_q     <= '0;
      duty_b_q     <= '0;
    end else begin
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      if (fade_step_we_i) begin
        fade_step_q <= fade_step_i;
      end
      line_cnt_q   <= line_cnt_d;
      first_char_q <= first_char_d;
      phase_q      <= phase_d;
      neg_q        <= neg_d;
      accum_q      <= accum_d;
      demo_q       <= demo_d;
      intensity_q  <= intensity_d;
      rising_q     <= rising_d;
      colour_q     <= colour_d;
      duty_r_q     <= duty_r_d;
      duty_g_q     <= duty_g_d;
      duty_b_q     <= duty_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      action_q <= action_i;
      byte_q   <= rx_byte_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duty_red_o    = duty_r_q;
  assign duty_green_o  = duty_g_q;
  assign duty_blue_o   = duty_b_q;
  assign demo_active_o = demo_q;

`ifndef SYNTHESIS
  a_line_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_cnt_q <= CNT_LAST)
    else $error("line count past line depth");

  a_colour_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    colour_q <= COLOUR_LAST)
    else $error("colour index out of range");

  a_demo_exit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(demo_q) |-> (duty_r_q == '0 && duty_g_q == '0 && duty_b_q == '0))
    else $error("duties not cleared on leaving demo");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(duty_r_q) && $stable(demo_q) && $stable(line_cnt_q)))
    else $error("state changed without a transfer");
`endif

endmodule
